### sv/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// LZW compressor package
// Word types, sizes and constants shared by the compressor modules.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	localparam int CODE_BITS_DEF   = 12;
	localparam int HASH_DEPTH_DEF  = 8192;
	localparam int SINGLE_CODES    = 256;
	localparam int OUT_CODE_W      = 12;
	localparam int LIMIT_W         = 13;
	localparam int LIMIT_RESET     = 4096;
	localparam int EPOCH_BITS      = 8;
	localparam int IN_DEPTH        = 2;
	localparam int OUT_DEPTH       = 4;
	localparam int OUT_CNT_W       = $clog2(OUT_DEPTH) + 1;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [OUT_CODE_W-1:0] out_code;
		logic                  last_code;
	} out_word_t;

endpackage

### sv/lzwc_ram.sv
// ----------------------------------------------------------------------------
// LZW compressor RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzwc_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/lzwc_fifo.sv
// ----------------------------------------------------------------------------
// LZW compressor word queue
// Small show-ahead FIFO in flip-flops, with fill count.
// ----------------------------------------------------------------------------
module lzwc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  logic [W-1:0]               wdata,
	input  logic                       rd,
	output logic [W-1:0]               rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH):0]     cnt
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign cnt   = cnt_q;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/lzwc_engine.sv
// ----------------------------------------------------------------------------
// LZW compressor engine
// Prefix tracking, hashed dictionary lookup with linear probing, insert, emit.
// ----------------------------------------------------------------------------
module lzwc_engine #(
	parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
	parameter int HASH_DEPTH = lzwc_pkg::HASH_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lzwc_pkg::LIMIT_W-1:0]     dict_limit,
	input  logic                             in_empty,
	input  lzwc_pkg::in_word_t               in_word,
	output logic                             in_pop,
	input  logic [lzwc_pkg::OUT_CNT_W-1:0]   out_cnt,
	output logic                             out_push,
	output lzwc_pkg::out_word_t              out_word
);

	localparam int HB     = $clog2(HASH_DEPTH);
	localparam int KEY_W  = CODE_BITS + 8;
	localparam int EW     = lzwc_pkg::EPOCH_BITS;
	localparam int ENT_W  = EW + KEY_W + CODE_BITS;
	localparam int NFC_W  = CODE_BITS + 1;
	localparam int CMP_W  = (NFC_W > lzwc_pkg::LIMIT_W) ? NFC_W : lzwc_pkg::LIMIT_W;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_HASH = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_EOM  = 3'd5;

	logic [2:0]           st_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 pvalid_q;
	logic [NFC_W-1:0]     nfc_q;
	logic [EW-1:0]        epoch_q;
	logic [HB-1:0]        idx_q;
	logic [HB:0]          probe_q;
	logic [7:0]           byte_q;
	logic                 eom_q;
	logic [KEY_W-1:0]     key_q;

	logic                 we;
	logic [ENT_W-1:0]     wdata;
	logic [ENT_W-1:0]     rdata;
	logic [EW-1:0]        e_epoch;
	logic [KEY_W-1:0]     e_key;
	logic [CODE_BITS-1:0] e_code;
	logic                 hit;
	logic                 slot_free;
	logic                 probe_end;
	logic                 can_insert;
	logic [CMP_W-1:0]     lim;
	logic [CMP_W-1:0]     cap;
	logic [CMP_W-1:0]     dl_ext;
	logic [31:0]          prod;

	lzwc_ram #(
		.W     (ENT_W),
		.DEPTH (HASH_DEPTH)
	) u_dict (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign e_epoch   = rdata[ENT_W-1 -: EW];
	assign e_key     = rdata[CODE_BITS +: KEY_W];
	assign e_code    = rdata[CODE_BITS-1:0];
	assign slot_free = (e_epoch != epoch_q);
	assign hit       = !slot_free && (e_key == key_q);
	assign probe_end = (probe_q == (HB+1)'(HASH_DEPTH - 1));

	// effective code limit: min(dict_limit, 2^CODE_BITS)
	assign cap        = CMP_W'(1) << CODE_BITS;
	assign dl_ext     = CMP_W'(dict_limit);
	assign lim        = (dl_ext < cap) ? dl_ext : cap;
	assign can_insert = (CMP_W'(nfc_q) < lim) && slot_free;

	assign prod = 32'(key_q) * lzwc_pkg::HASH_MULT;

	assign in_pop = (st_q == ST_IDLE) && !in_empty &&
	                (out_cnt <= lzwc_pkg::OUT_CNT_W'(lzwc_pkg::OUT_DEPTH - 2));

	assign we    = (st_q == ST_CLR) || ((st_q == ST_CMP) && !hit && can_insert);
	assign wdata = (st_q == ST_CLR) ? '0 : {epoch_q, key_q, CODE_BITS'(nfc_q)};

	always_comb begin
		out_push = 1'b0;
		out_word.out_code  = lzwc_pkg::OUT_CODE_W'(prefix_q);
		out_word.last_code = 1'b0;
		case (st_q)
			ST_CMP: begin
				out_push = !hit && (slot_free || probe_end);
			end
			ST_EOM: begin
				out_push = 1'b1;
				out_word.last_code = 1'b1;
			end
			default: begin
				out_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			byte_q <= in_word.data_byte;
			eom_q  <= in_word.end_of_message;
			key_q  <= {prefix_q, in_word.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLR;
			prefix_q <= '0;
			pvalid_q <= 1'b0;
			nfc_q    <= NFC_W'(lzwc_pkg::SINGLE_CODES);
			epoch_q  <= EW'(1);
			idx_q    <= '0;
			probe_q  <= '0;
		end else begin
			case (st_q)
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == HB'(HASH_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_pop) begin
						if (!pvalid_q) begin
							prefix_q <= CODE_BITS'(in_word.data_byte);
							pvalid_q <= 1'b1;
							st_q     <= in_word.end_of_message ? ST_EOM : ST_IDLE;
						end else begin
							st_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					idx_q   <= prod[8 +: HB];
					probe_q <= '0;
					st_q    <= ST_RD;
				end
				ST_RD: begin
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						prefix_q <= e_code;
						st_q     <= eom_q ? ST_EOM : ST_IDLE;
					end else if (slot_free || probe_end) begin
						if (can_insert) begin
							nfc_q <= nfc_q + 1'b1;
						end
						prefix_q <= CODE_BITS'(byte_q);
						st_q     <= eom_q ? ST_EOM : ST_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						st_q    <= ST_RD;
					end
				end
				ST_EOM: begin
					prefix_q <= '0;
					pvalid_q <= 1'b0;
					nfc_q    <= NFC_W'(lzwc_pkg::SINGLE_CODES);
					// advance the epoch; on wrap, wipe the table before reuse
					if (epoch_q == {EW{1'b1}}) begin
						epoch_q <= EW'(1);
						idx_q   <= '0;
						st_q    <= ST_CLR;
					end else begin
						epoch_q <= epoch_q + 1'b1;
						st_q    <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |-> (st_q == ST_IDLE))
		else $error("input popped outside idle");

	a_nfc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(nfc_q) <= cap))
		else $error("next free code beyond code space");

	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (st_q != ST_CLR)) |-> (epoch_q != '0))
		else $error("insert with clear epoch");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (out_cnt < lzwc_pkg::OUT_CNT_W'(lzwc_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

endmodule

### sv/lzw_byte_compressor.sv
// Path: a word at the input queue head is taken, hashed, read and compared before any code it causes
// enters the result queue; each extra probe repeats read and compare, and end of message adds an end step.
// No new word is taken until the last is done; a message's first byte needs only the take step.
// Reset: asynchronous, active low; then a clearing pass over every dictionary entry runs
// before any word is taken, and again after every 255 messages (epoch wrap).
// The config write channel is always ready.
// ----------------------------------------------------------------------------
// LZW byte compressor
// Byte-in, code-out LZW compressor with a hashed dictionary and code limit.
// ----------------------------------------------------------------------------
module lzw_byte_compressor #(
	parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
	parameter int HASH_DEPTH = lzwc_pkg::HASH_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          push,
	output logic                          full,
	input  lzwc_pkg::in_word_t            in_word,
	// result words
	output logic                          empty,
	input  logic                          pop,
	output lzwc_pkg::out_word_t           out_word,
	// dict_limit register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lzwc_pkg::LIMIT_W-1:0]  cfg_data
);

	logic [lzwc_pkg::LIMIT_W-1:0]   dict_limit_q;
	logic                           in_empty;
	logic                           in_pop;
	lzwc_pkg::in_word_t             in_head;
	logic [$clog2(lzwc_pkg::IN_DEPTH):0] in_cnt;
	logic                           out_push;
	lzwc_pkg::out_word_t            eng_word;
	logic                           out_full;
	logic [lzwc_pkg::OUT_CNT_W-1:0] out_cnt;

	// hold the code limit; it is read live at each insert
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_limit_q <= lzwc_pkg::LIMIT_W'(lzwc_pkg::LIMIT_RESET);
		end else if (cfg_valid && cfg_ready) begin
			dict_limit_q <= cfg_data;
		end
	end

	// front: buffer incoming bytes; the sender waits on a probe only when this queue is full
	lzwc_fifo #(
		.W     ($bits(lzwc_pkg::in_word_t)),
		.DEPTH (lzwc_pkg::IN_DEPTH)
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (in_word),
		.rd     (in_pop),
		.rdata  (in_head),
		.full   (full),
		.empty  (in_empty),
		.cnt    (in_cnt)
	);

	// back: lookup, insert and emit
	lzwc_engine #(
		.CODE_BITS  (CODE_BITS),
		.HASH_DEPTH (HASH_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.dict_limit (dict_limit_q),
		.in_empty   (in_empty),
		.in_word    (in_head),
		.in_pop     (in_pop),
		.out_cnt    (out_cnt),
		.out_push   (out_push),
		.out_word   (eng_word)
	);

	// result queue; the engine only takes a byte with room for two codes
	lzwc_fifo #(
		.W     ($bits(lzwc_pkg::out_word_t)),
		.DEPTH (lzwc_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (eng_word),
		.rd     (pop),
		.rdata  (out_word),
		.full   (out_full),
		.empty  (empty),
		.cnt    (out_cnt)
	);

	a_in_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (in_cnt != '0))
		else $error("input queue full while empty");

	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_full |-> !out_push)
		else $error("push into full result queue");

	a_limit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(dict_limit_q))
		else $error("code limit changed without a write");

endmodule

### sim/tb_lzw_byte_compressor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW byte compressor testbench
// Feeds byte messages through the compressor, predicts every emitted code with
// an in-bench LZW dictionary and compares each popped word field by field.
// ----------------------------------------------------------------------------
module tb_lzw_byte_compressor;

	localparam int CODE_CAP = 4096;

	// One directed row: a byte, its end flag, and optionally the single code that
	// the row must produce (written in where it is obvious).
	typedef struct {
		logic [7:0]  data_byte;
		logic        eom;
		bit          typed;
		logic [11:0] code;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	lzwc_pkg::in_word_t            in_word = '0;
	logic                          empty;
	logic                          pop = 1'b0;
	lzwc_pkg::out_word_t           out_word;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [lzwc_pkg::LIMIT_W-1:0]  cfg_data = '0;

	// Predictor state: prefix, next code, limit, and the pair -> code dictionary.
	logic [11:0]         pfx_code;
	bit                  pfx_live;
	int unsigned         free_code;
	int unsigned         dict_limit_q;
	logic [11:0]         pair_dict [int unsigned];

	lzwc_pkg::out_word_t code_q [$];
	int                  errors = 0;
	int                  words_in = 0;
	int                  words_out = 0;
	int                  messages = 0;
	bit                  quiet = 1'b0;
	row_t                rows [$];

	lzw_byte_compressor uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("lzw_byte_compressor: mismatch");
		$finish;
	end

	// Work out the codes one accepted word causes and queue them; return count.
	function automatic int lzw_predict(lzwc_pkg::in_word_t w);
		int unsigned key;
		int unsigned lim;
		int n;
		lzwc_pkg::out_word_t r;
		n = 0;
		if (!pfx_live) begin
			pfx_code = 12'(w.data_byte);
			pfx_live = 1'b1;
		end else begin
			key = 32'({pfx_code, w.data_byte});
			if (pair_dict.exists(key)) begin
				pfx_code = pair_dict[key];
			end else begin
				r.out_code = pfx_code;
				r.last_code = 1'b0;
				code_q.push_back(r);
				n++;
				lim = (dict_limit_q < CODE_CAP) ? dict_limit_q : CODE_CAP;
				if (free_code < lim) begin
					pair_dict[key] = free_code[11:0];
					free_code++;
				end
				pfx_code = 12'(w.data_byte);
			end
		end
		if (w.end_of_message) begin
			r.out_code = pfx_code;
			r.last_code = 1'b1;
			code_q.push_back(r);
			n++;
			pfx_code = '0;
			pfx_live = 1'b0;
			pair_dict.delete();
			free_code = lzwc_pkg::SINGLE_CODES;
			messages++;
		end
		return n;
	endfunction

	// Send one byte; push stays high across back-to-back words.
	task automatic send_byte(logic [7:0] b, logic eom);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_word <= '{data_byte: b, end_of_message: eom};
		do @(posedge clk); while (full);
		words_in++;
	endtask

	// Hold until every expected code is out, then let the pipe drain fully.
	task automatic drain;
		push <= 1'b0;
		while (code_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [lzwc_pkg::LIMIT_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dict_limit_q = 32'(v);
	endtask

	task automatic send_checked(logic [7:0] b, logic eom);
		void'(lzw_predict('{data_byte: b, end_of_message: eom}));
		send_byte(b, eom);
	endtask

	// Random message: mostly a narrow alphabet so strings repeat and grow.
	task automatic random_message(int len, int alpha);
		int i;
		logic [7:0] base;
		base = 8'($urandom_range(0, 255));
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_checked(8'($urandom_range(0, 255)), i == len - 1);
			else
				send_checked(base ^ 8'($urandom_range(0, alpha - 1)), i == len - 1);
		end
	endtask

	// Result side: random stall bursts, compare each popped word in order.
	int stall = 0;
	always @(posedge clk) begin
		lzwc_pkg::out_word_t e;
		if (pop && !empty) begin
			words_out++;
			if (code_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h/%b", $time,
					out_word.out_code, out_word.last_code);
				errors++;
			end else begin
				e = code_q.pop_front();
				if (out_word.out_code !== e.out_code || out_word.last_code !== e.last_code) begin
					$display("%0t: expected code %h last %b, actual code %h last %b", $time,
						e.out_code, e.last_code, out_word.out_code, out_word.last_code);
					errors++;
				end
			end
		end
		if (stall > 0) begin
			stall <= stall - 1;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall <= $urandom_range(1, 18);
			pop <= 1'b0;
		end else begin
			pop <= arst_n;
		end
	end

	initial begin
		int i, n, len;
		lzwc_pkg::out_word_t got;
		pfx_code = '0;
		pfx_live = 1'b0;
		free_code = lzwc_pkg::SINGLE_CODES;
		dict_limit_q = lzwc_pkg::LIMIT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, single-byte messages, repeats that hit the dictionary.
		rows.push_back('{8'h00, 1'b1, 1'b1, 12'h000});
		rows.push_back('{8'hff, 1'b1, 1'b1, 12'h0ff});
		rows.push_back('{8'h41, 1'b0, 1'b1, 12'h000});  // empty prefix: no code yet
		rows.push_back('{8'h42, 1'b0, 1'b1, 12'h041});
		rows.push_back('{8'h41, 1'b0, 1'b1, 12'h042});
		rows.push_back('{8'h42, 1'b0, 1'b0, 12'h000});  // AB hits
		rows.push_back('{8'h41, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h42, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h41, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h42, 1'b1, 1'b0, 12'h000});
		rows.push_back('{8'haa, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h55, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'haa, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h55, 1'b1, 1'b0, 12'h000});
		rows.push_back('{8'h80, 1'b0, 1'b0, 12'h000});
		rows.push_back('{8'h01, 1'b1, 1'b0, 12'h000});
		foreach (rows[k]) begin
			n = lzw_predict('{data_byte: rows[k].data_byte, end_of_message: rows[k].eom});
			if (rows[k].typed) begin
				got = code_q.size() ? code_q[$] : '0;
				if ((rows[k].code == 0 && !rows[k].eom && n != 0) ||
					(rows[k].code != 0 && (n == 0 || got.out_code != rows[k].code))) begin
					$display("%0t: row %0d expected code %h, actual %h", $time, k,
						rows[k].code, got.out_code);
					errors++;
				end
			end
			send_byte(rows[k].data_byte, rows[k].eom);
		end

		// Small limits: one entry, then none at all.
		write_limit(13'd257);
		random_message(20, 2);
		write_limit(13'd256);
		random_message(15, 2);
		// Beyond the code width acts as the full width; also the all-ones value.
		write_limit(13'h1fff);
		random_message(30, 3);
		// Freeze the dictionary partway through a long message.
		write_limit(13'd300);
		random_message(300, 2);
		write_limit(lzwc_pkg::LIMIT_W'(lzwc_pkg::LIMIT_RESET));

		// Random part, with the limit changed between phases.
		while (words_in < 950) begin
			if ($urandom_range(0, 12) == 0)
				write_limit($urandom_range(0, 1) ? 13'($urandom_range(257, 600))
					: 13'($urandom_range(0, 8191)));
			if ($urandom_range(0, 15) == 0)
				drain();
			if (words_in > 800)
				quiet = 1'b1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
			random_message(len, $urandom_range(1, 16));
		end
		push <= 1'b0;

		i = 0;
		while (code_q.size() != 0 && i < 200000) begin
			@(posedge clk);
			i++;
		end
		repeat (60) @(posedge clk);
		$display("Sent %0d bytes in %0d messages, checked %0d codes.",
			words_in, messages, words_out);
		$display("Limits from none-added to beyond width; random idle on both sides.");
		if (errors == 0 && code_q.size() == 0)
			$display("lzw_byte_compressor: match");
		else
			$display("lzw_byte_compressor: mismatch");
		$finish;
	end

endmodule
